/* hdl/u8u16_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

    // Width of a Unicode scalar value up to U+10FFFF.
    localparam int CODE_W = 21;
    // Result words (16 bits each) that one input byte can cause.
    localparam int SLOTS  = 3;

    localparam logic [15:0]       BOM_WORD    = 16'hFEFF;
    localparam logic [CODE_W-1:0] MAX_CODE    = 21'h10FFFF;
    localparam logic [5:0]        HI_SURR_TAG = 6'b110110;
    localparam logic [5:0]        LO_SURR_TAG = 6'b110111;
    localparam logic [4:0]        SURR_TOP5   = 5'b11011;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_of_string;
        logic       last_of_string;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } t_out_item;

    // Words of one encoded code point: none, one, or a surrogate pair.
    typedef struct packed {
        logic [1:0]       cnt;
        logic [1:0][15:0] word;
    } t_code_words;

    // Everything one input byte produces, in order, word 0 first.
    typedef struct packed {
        logic [1:0]             words;
        logic [SLOTS-1:0][15:0] word;
    } t_emit;

    // Encodes a code point as UTF-16. Out-of-range values and lone
    // surrogate values give no words.
    function automatic t_code_words encode_code(input logic [CODE_W-1:0] cp,
                                                input logic over);
        t_code_words r;
        logic [19:0] v;
        r = '0;
        v = cp[19:0] - 20'h10000;
        if (over) begin
            r.cnt = 2'd0;
        end else if (cp[CODE_W-1:16] != '0) begin
            r.cnt     = 2'd2;
            r.word[0] = {HI_SURR_TAG, v[19:10]};
            r.word[1] = {LO_SURR_TAG, v[9:0]};
        end else if (cp[15:11] == SURR_TOP5) begin
            r.cnt = 2'd0;
        end else begin
            r.cnt     = 2'd1;
            r.word[0] = cp[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/utf8_to_utf16be_transcoder.sv */
`timescale 1ns / 1ps
`default_nettype none

// UTF-8 to UTF-16BE transcoder. UTF-8 bytes arrive one per transfer, framed
// by first and last markers, and big-endian UTF-16 bytes leave one per
// transfer; each string opens with the order mark FE FF, code points above
// U+FFFF become surrogate pairs, and code points beyond U+10FFFF or inside
// the surrogate range are dropped without notice. A code point is written
// out when the following lead byte arrives or when the string ends, and
// run_last marks the final output byte caused by one input byte. The output
// side is byte wide and moves one byte per cycle while i_out_ready is high;
// an input byte causes 0 to 6 output bytes: two for a typical character and
// four for a surrogate pair, with two more on the first byte of a string
// for the order mark. An input register in front of the six-byte result
// buffer lets the next byte be taken while the current results drain; an
// input byte's results pass through that register and then the result
// buffer before they reach the output.
module utf8_to_utf16be_transcoder (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire u8u16_pkg::t_in_item  i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output u8u16_pkg::t_out_item      o_out_item
);
    import u8u16_pkg::*;

    localparam int BUF_BYTES = 2 * SLOTS;

    // Input holding register.
    logic     r_in_valid;
    t_in_item r_in_item;

    // Result buffer: byte 0 is the head, r_cnt bytes are live.
    logic [BUF_BYTES-1:0][7:0] r_buf, n_buf;
    logic [2:0]                r_cnt, n_cnt;

    logic  buf_free;
    logic  advance;
    logic  take;
    t_emit emit;

    // The buffer can be refilled once its last byte is leaving.
    assign buf_free   = (r_cnt == 3'd0) || (r_cnt == 3'd1 && i_out_ready);
    assign advance    = r_in_valid && buf_free;
    assign take       = o_out_valid && i_out_ready;
    assign o_in_ready = !r_in_valid || advance;

    u8u16_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .o_emit    (emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        if (advance) begin
            // Every result word is two bytes, high byte first.
            n_cnt = {emit.words, 1'b0};
            for (int k = 0; k < SLOTS; k++) begin
                n_buf[2*k]   = emit.word[k][15:8];
                n_buf[2*k+1] = emit.word[k][7:0];
            end
        end else if (take) begin
            n_cnt = r_cnt - 3'd1;
            for (int k = 0; k < BUF_BYTES - 1; k++) begin
                n_buf[k] = r_buf[k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    assign o_out_valid         = (r_cnt != 3'd0);
    assign o_out_item.out_byte = r_buf[0];
    assign o_out_item.run_last = (r_cnt == 3'd1);

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(BUF_BYTES))
        else $error("result buffer count beyond capacity");

    a_even_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> !r_cnt[0])
        else $error("odd number of bytes loaded into the result buffer");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !buf_free) |=> (r_in_valid && $stable(r_in_item)))
        else $error("held input byte lost while the buffer was busy");

    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_cnt != 3'd1) |=> o_out_valid)
        else $error("gap inside the output bytes of one input byte");

endmodule

`default_nettype wire

/* hdl/u8u16_decode.sv */
`timescale 1ns / 1ps
`default_nettype none

module u8u16_decode (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_advance,
    input  wire u8u16_pkg::t_in_item i_item,
    output u8u16_pkg::t_emit         o_emit
);
    import u8u16_pkg::*;

    // Pending code point; r_over stands for any value above U+10FFFF.
    logic [CODE_W-1:0] r_pc, n_pc;
    logic              r_over, n_over;
    logic              r_pv, n_pv;

    logic [CODE_W-1:0] pc0, pc1;
    logic              over0, over1, pv0, pv1;
    logic              cont;
    logic [CODE_W+5:0] shifted;
    t_code_words       code_a, code_c;
    logic [1:0]        nb, slot, rel, rel2;
    t_emit             emit;

    always_comb begin
        pc0     = i_item.first_of_string ? '0 : r_pc;
        over0   = i_item.first_of_string ? 1'b0 : r_over;
        pv0     = i_item.first_of_string ? 1'b0 : r_pv;
        cont    = (i_item.in_byte[7:6] == 2'b10);
        shifted = {pc0, i_item.in_byte[5:0]};
        code_a  = '0;
        code_c  = '0;
        pv1     = 1'b1;
        if (cont) begin
            if (over0) begin
                over1 = 1'b1;
                pc1   = pc0;
            end else begin
                over1 = (shifted > {6'd0, MAX_CODE});
                pc1   = shifted[CODE_W-1:0];
            end
        end else begin
            if (pv0) begin
                code_a = encode_code(pc0, over0);
            end
            over1 = 1'b0;
            if (!i_item.in_byte[7]) begin
                pc1 = {13'd0, i_item.in_byte};
            end else if (i_item.in_byte <= 8'hDF) begin
                pc1 = {16'd0, i_item.in_byte[4:0]};
            end else if (i_item.in_byte <= 8'hEF) begin
                pc1 = {17'd0, i_item.in_byte[3:0]};
            end else begin
                pc1 = {18'd0, i_item.in_byte[2:0]};
            end
        end

        if (i_item.last_of_string) begin
            code_c = encode_code(pc1, over1);
            n_pc   = '0;
            n_over = 1'b0;
            n_pv   = 1'b0;
        end else begin
            n_pc   = pc1;
            n_over = over1;
            n_pv   = pv1;
        end

        // Order mark, then the flushed code point, then the one ended by
        // the last marker.
        nb         = {1'b0, i_item.first_of_string};
        emit.words = nb + code_a.cnt + code_c.cnt;
        emit.word  = '0;
        slot       = '0;
        rel        = '0;
        rel2       = '0;
        for (int s = 0; s < SLOTS; s++) begin
            slot = 2'(s);
            rel  = slot - nb;
            rel2 = rel - code_a.cnt;
            if (slot < nb) begin
                emit.word[s] = BOM_WORD;
            end else if (rel < code_a.cnt) begin
                emit.word[s] = code_a.word[rel[0]];
            end else begin
                emit.word[s] = code_c.word[rel2[0]];
            end
        end
    end

    assign o_emit = emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_over <= 1'b0;
            r_pv   <= 1'b0;
        end else if (i_advance) begin
            r_pc   <= n_pc;
            r_over <= n_over;
            r_pv   <= n_pv;
        end
    end

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pv |-> (r_pc == '0 && !r_over))
        else $error("pending code not cleared while nothing is pending");

    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_over |-> (r_pc <= MAX_CODE))
        else $error("pending code out of range without overflow mark");

endmodule

`default_nettype wire
